// ===== rtl/crsi_pkg.sv =====
package crsi_pkg;

  // Ratio table size and the choice that means 1:1.
  localparam int RatioCount  = 11;
  localparam int UnityChoice = 5;

  // Swing divisor center and the width of the shifted swing knob.
  localparam int SwingUnity = 32768;
  localparam int SwingW     = 14;

  // Default depth of the queue between front and back.
  localparam int QueueDepth = 2;

  // Divider geometry: a 48-bit dividend, four quotient bits per stage.
  localparam int NumW      = 48;
  localparam int StepBits  = 4;
  localparam int DivStages = NumW / StepBits;

  // Reciprocal of three for a 32-bit dividend, used with a shift of 33.
  localparam logic [31:0] RecipThree = 32'hAAAA_AAAB;

  // Numerator B of each ratio.
  function automatic logic [3:0] ratio_num(input logic [3:0] choice);
    logic [3:0] b;
    case (choice)
      4'd4:    b = 4'd2;
      4'd6:    b = 4'd3;
      4'd7:    b = 4'd2;
      4'd8:    b = 4'd3;
      4'd9:    b = 4'd4;
      4'd10:   b = 4'd8;
      default: b = 4'd1;
    endcase
    return b;
  endfunction

  // Denominator A of each ratio.
  function automatic logic [3:0] ratio_den(input logic [3:0] choice);
    logic [3:0] a;
    case (choice)
      4'd0:    a = 4'd8;
      4'd1:    a = 4'd4;
      4'd2:    a = 4'd3;
      4'd3:    a = 4'd2;
      4'd4:    a = 4'd3;
      4'd6:    a = 4'd2;
      default: a = 4'd1;
    endcase
    return a;
  endfunction

  // One queued item after classification.
  typedef struct packed {
    logic [31:0]       master;
    logic [3:0]        choice_b;
    logic [3:0]        choice_c;
    logic [3:0]        choice_d;
    logic [SwingW-1:0] swing;
    logic              ext;
  } crsi_item_t;

  // Sideband that travels with each channel through the back end.
  typedef struct packed {
    logic [1:0] chan;
    logic [3:0] choice;
    logic       ext;
    logic       last;
  } crsi_tag_t;

  // Working state of the two dividers in one stage.
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [15:0]     rem1;
    logic [15:0]     rem2;
    logic [15:0]     den1;
    logic [15:0]     den2;
    logic [31:0]     quo1;
    logic [31:0]     quo2;
  } crsi_div_t;

endpackage

// ===== rtl/crsi_if.sv =====
interface crsi_in_if;
  logic        valid;
  logic        ready;
  logic        external_select;
  logic [31:0] ext_clock_inc;
  logic [31:0] internal_increment;
  logic [15:0] ratio_knob_b;
  logic [15:0] ratio_knob_c;
  logic [15:0] ratio_knob_d;
  logic [15:0] swing_knob;

  modport source(output valid, external_select, ext_clock_inc, internal_increment,
                 ratio_knob_b, ratio_knob_c, ratio_knob_d, swing_knob, input ready);
  modport sink(input valid, external_select, ext_clock_inc, internal_increment,
               ratio_knob_b, ratio_knob_c, ratio_knob_d, swing_knob, output ready);
endinterface

interface crsi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic [3:0]  ratio_choice;
  logic [31:0] first_half_increment;
  logic [31:0] second_half_increment;
  logic        external_sync;
  logic        last;

  modport source(output valid, channel, ratio_choice, first_half_increment,
                 second_half_increment, external_sync, last, input ready);
  modport sink(input valid, channel, ratio_choice, first_half_increment,
               second_half_increment, external_sync, last, output ready);
endinterface

// ===== rtl/crsi_front.sv =====
module crsi_front import crsi_pkg::*; (
  crsi_in_if.sink    in_bus,
  input  logic       push_ready,
  output logic       push_valid,
  output crsi_item_t push_item
);

  // Knob to ratio choice: (knob * 11) >> 16, clamped to the table.
  function automatic logic [3:0] knob_to_choice(input logic [15:0] knob);
    logic [19:0] prod;
    logic [3:0]  c;
    prod = {4'b0, knob} * 20'(RatioCount);
    c    = prod[19:16];
    if (c > 4'(RatioCount - 1)) c = 4'(RatioCount - 1);
    return c;
  endfunction

  // Pick the master, classify the knobs and hand the beat to the queue.
  assign push_valid         = in_bus.valid;
  assign in_bus.ready       = push_ready;
  assign push_item.master   = in_bus.external_select ? in_bus.ext_clock_inc
                                                     : in_bus.internal_increment;
  assign push_item.choice_b = knob_to_choice(in_bus.ratio_knob_b);
  assign push_item.choice_c = knob_to_choice(in_bus.ratio_knob_c);
  assign push_item.choice_d = knob_to_choice(in_bus.ratio_knob_d);
  assign push_item.swing    = in_bus.swing_knob[15:2];
  assign push_item.ext      = in_bus.external_select;

endmodule

// ===== rtl/crsi_queue.sv =====
module crsi_queue import crsi_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  crsi_item_t push_item,
  output logic       pop_valid,
  input  logic       pop,
  output crsi_item_t pop_item
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  crsi_item_t        slot_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CntW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/crsi_div_stage.sv =====
module crsi_div_stage import crsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  crsi_tag_t in_tag,
  input  crsi_div_t in_div,
  output logic      out_valid,
  output crsi_tag_t out_tag,
  output crsi_div_t out_div
);

  crsi_div_t div_nxt;
  logic      valid_r;
  crsi_tag_t tag_r;
  crsi_div_t div_r;

  // Restoring division steps for both half-cycle divisors.
  always_comb begin
    logic [16:0] t1, t2;
    div_nxt = in_div;
    for (int i = 0; i < StepBits; i++) begin
      t1 = {div_nxt.rem1, div_nxt.num[NumW-1]};
      t2 = {div_nxt.rem2, div_nxt.num[NumW-1]};
      div_nxt.num = {div_nxt.num[NumW-2:0], 1'b0};
      if (t1 >= {1'b0, div_nxt.den1}) begin
        t1 = t1 - {1'b0, div_nxt.den1};
        div_nxt.quo1 = {div_nxt.quo1[30:0], 1'b1};
      end else begin
        div_nxt.quo1 = {div_nxt.quo1[30:0], 1'b0};
      end
      if (t2 >= {1'b0, div_nxt.den2}) begin
        t2 = t2 - {1'b0, div_nxt.den2};
        div_nxt.quo2 = {div_nxt.quo2[30:0], 1'b1};
      end else begin
        div_nxt.quo2 = {div_nxt.quo2[30:0], 1'b0};
      end
      div_nxt.rem1 = t1[15:0];
      div_nxt.rem2 = t2[15:0];
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= in_tag;
      div_r <= div_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_tag   = tag_r;
  assign out_div   = div_r;

endmodule

// ===== rtl/crsi_back.sv =====
module crsi_back import crsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  crsi_item_t q_item,
  output logic       q_pop,
  crsi_out_if.source out_bus
);

  logic                en;
  logic [1:0]          cnt_r;
  logic                issue;
  logic [3:0]          issue_choice;

  logic                s1_v_r, s2_v_r, s3_v_r;
  logic [31:0]         s1_m_r, s2_m_r;
  logic [SwingW-1:0]   s1_swing_r, s2_swing_r;
  crsi_tag_t           s1_tag_r, s2_tag_r, s3_tag_r;
  logic [63:0]         s2_prod_r;
  crsi_div_t           s3_div_r;

  logic [3:0]          den_a, num_b;
  logic [31:0]         quo, rem_full, base;
  logic [35:0]         qb_full;
  logic [6:0]          rb, rbq;
  logic [10:0]         rb_third;

  logic                st_v   [DivStages+1];
  crsi_tag_t           st_tag [DivStages+1];
  crsi_div_t           st_div [DivStages+1];

  logic                out_valid_r;
  crsi_tag_t           out_tag_r;
  logic [31:0]         first_r, second_r;

  // The whole back end advances unless a finished beat is stuck at the output.
  assign en    = !out_valid_r || out_bus.ready;
  assign issue = en && q_valid;
  assign q_pop = issue && (cnt_r == 2'd3);

  // Channel sequencer: four channels per queued item.
  always_comb begin
    case (cnt_r)
      2'd0:    issue_choice = 4'(UnityChoice);
      2'd1:    issue_choice = q_item.choice_b;
      2'd2:    issue_choice = q_item.choice_c;
      default: issue_choice = q_item.choice_d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      if (issue) cnt_r <= cnt_r + 1'b1;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Issue register and the reciprocal product for division by three.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_r          <= q_item.master;
      s1_swing_r      <= q_item.swing;
      s1_tag_r.chan   <= cnt_r;
      s1_tag_r.choice <= issue_choice;
      s1_tag_r.ext    <= q_item.ext;
      s1_tag_r.last   <= (cnt_r == 2'd3);
      s2_prod_r       <= s1_m_r * RecipThree;
      s2_m_r          <= s1_m_r;
      s2_swing_r      <= s1_swing_r;
      s2_tag_r        <= s1_tag_r;
    end
  end

  // Ratio scaling in quotient and remainder form, modulo 2^32.
  always_comb begin
    den_a = ratio_den(s2_tag_r.choice);
    num_b = ratio_num(s2_tag_r.choice);
    case (den_a)
      4'd8:    quo = {3'b0, s2_m_r[31:3]};
      4'd4:    quo = {2'b0, s2_m_r[31:2]};
      4'd2:    quo = {1'b0, s2_m_r[31:1]};
      4'd1:    quo = s2_m_r;
      default: quo = {1'b0, s2_prod_r[63:33]};
    endcase
    rem_full = s2_m_r - (quo * {28'b0, den_a});
    qb_full  = {4'b0, quo} * {32'b0, num_b};
    rb       = {4'b0, rem_full[2:0]} * {3'b0, num_b};
    // The remainder product is at most 4 here, so (rb * 11) >> 5 is rb / 3.
    rb_third = {4'b0, rb} * 11'd11;
    case (den_a)
      4'd8:    rbq = {3'b0, rb[6:3]};
      4'd4:    rbq = {2'b0, rb[6:2]};
      4'd2:    rbq = {1'b0, rb[6:1]};
      4'd1:    rbq = rb;
      default: rbq = {1'b0, rb_third[10:5]};
    endcase
    base = qb_full[31:0] + {25'b0, rbq};
  end

  // Load the dividers with base * 32768 and the two swing divisors.
  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag_r      <= s2_tag_r;
      s3_div_r.num  <= {1'b0, base, 15'b0};
      s3_div_r.rem1 <= '0;
      s3_div_r.rem2 <= '0;
      s3_div_r.den1 <= 16'(SwingUnity) + {2'b0, s2_swing_r};
      s3_div_r.den2 <= 16'(SwingUnity) - {2'b0, s2_swing_r};
      s3_div_r.quo1 <= '0;
      s3_div_r.quo2 <= '0;
    end
  end

  assign st_v[0]   = s3_v_r;
  assign st_tag[0] = s3_tag_r;
  assign st_div[0] = s3_div_r;

  // Pipelined divider, four quotient bits per stage.
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    crsi_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (st_v[g]),
      .in_tag    (st_tag[g]),
      .in_div    (st_div[g]),
      .out_valid (st_v[g+1]),
      .out_tag   (st_tag[g+1]),
      .out_div   (st_div[g+1])
    );
  end

  // Output register with the minimum-of-one rule.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_v[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag_r <= st_tag[DivStages];
      first_r   <= (st_div[DivStages].quo1 == '0) ? 32'd1 : st_div[DivStages].quo1;
      second_r  <= (st_div[DivStages].quo2 == '0) ? 32'd1 : st_div[DivStages].quo2;
    end
  end

  assign out_bus.valid                 = out_valid_r;
  assign out_bus.channel               = out_tag_r.chan;
  assign out_bus.ratio_choice          = out_tag_r.choice;
  assign out_bus.first_half_increment  = first_r;
  assign out_bus.second_half_increment = second_r;
  assign out_bus.external_sync         = out_tag_r.ext;
  assign out_bus.last                  = out_tag_r.last;

endmodule

// ===== rtl/clock_ratio_swing_increments.sv =====
// Clock ratio and swing increment generator.
//
// in_bus takes one control beat: the master select, the external and
// internal phase increments, three ratio knobs and the swing knob. out_bus
// gives four beats per control beat, channels 0 to 3 in order, with last
// set on channel 3. Channel 0 always runs at 1:1.
//
// Throughput is one output beat per cycle while out_bus does not stall;
// the four-channel sequencer in the back end takes a control beat from the
// queue once its four channels have issued. From the edge that accepts
// an input beat into the queue, its channel 0 result passes the issue
// register, the reciprocal multiply, ratio scaling into the divider load,
// twelve divider stages of four bits each and the output register.
//
// Reset clears the queue, the sequencer and every stage valid; no beats
// come out until new input arrives. When out_bus stalls, the back end
// holds in place and the queue absorbs input until full, after which
// in_bus.ready drops.
module clock_ratio_swing_increments import crsi_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  crsi_in_if.sink    in_bus,
  crsi_out_if.source out_bus
);

  logic       push_valid, push_ready, pop_valid, pop;
  crsi_item_t push_item, pop_item;

  // Front: master select and knob classification.
  crsi_front u_front (
    .in_bus     (in_bus),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // Queue between front and back.
  crsi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // Back: channel sequencing, ratio scaling and swing division.
  crsi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_item  (pop_item),
    .q_pop   (pop),
    .out_bus (out_bus)
  );

endmodule

// ===== rtl/crsi_checker.sv =====
module crsi_checker import crsi_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  channel,
  input logic [3:0]  ratio_choice,
  input logic [31:0] first_half_increment,
  input logic [31:0] second_half_increment,
  input logic        last
);

  // A stalled output beat keeps its channel.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(channel))
    else $error("output beat changed while stalled");

  // The last flag marks channel 3 and nothing else.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last == (channel == 2'd3)))
    else $error("last flag does not match channel 3");

  // Channel 0 always carries the 1:1 ratio.
  a_unity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && channel == 2'd0 |-> ratio_choice == 4'(UnityChoice))
    else $error("channel 0 ratio is not 1:1");

  // Increments are never zero.
  a_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> first_half_increment != '0 && second_half_increment != '0)
    else $error("zero half-cycle increment");

endmodule

bind clock_ratio_swing_increments crsi_checker u_crsi_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_bus.valid),
  .out_ready             (out_bus.ready),
  .channel               (out_bus.channel),
  .ratio_choice          (out_bus.ratio_choice),
  .first_half_increment  (out_bus.first_half_increment),
  .second_half_increment (out_bus.second_half_increment),
  .last                  (out_bus.last)
);

// ===== tb/sv/crsi_checker.sv =====
`timescale 1ns / 100ps

module crsi_scoreboard import crsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  crsi_in_if          in_bus,
  crsi_out_if         out_bus,
  output int unsigned fail_count,
  output int unsigned pending_beats
);

  typedef struct packed {
    logic [1:0]  chan;
    logic [3:0]  choice;
    logic [31:0] first_inc;
    logic [31:0] second_inc;
    logic        ext;
    logic        last;
  } channel_result_t;

  channel_result_t pending_q[$];

  // Ratio table, numerator and denominator per choice.
  logic [3:0] num_tab [RatioCount] = '{4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1,
                                       4'd3, 4'd2, 4'd3, 4'd4, 4'd8};
  logic [3:0] den_tab [RatioCount] = '{4'd8, 4'd4, 4'd3, 4'd2, 4'd3, 4'd1,
                                       4'd2, 4'd1, 4'd1, 4'd1, 4'd1};

  function automatic logic [3:0] knob_choice(input logic [15:0] knob);
    logic [19:0] prod;
    prod = 20'(knob) * 20'd11;
    return (prod[19:16] > 4'd10) ? 4'd10 : prod[19:16];
  endfunction

  function automatic logic [31:0] ratio_scaled(input logic [31:0] m, input logic [3:0] c);
    logic [31:0] b, a, q, r;
    b = 32'(num_tab[c]);
    a = 32'(den_tab[c]);
    q = m / a;
    r = m % a;
    return q * b + (r * b) / a;
  endfunction

  function automatic logic [31:0] half_inc(input logic [31:0] base, input logic [16:0] den);
    logic [63:0] v;
    v = ({32'd0, base} << 15) / 64'(den);
    return (v[31:0] == 32'd0) ? 32'd1 : v[31:0];
  endfunction

  // Predict the four channel beats for one accepted control beat.
  task automatic predict_channels();
    logic [31:0] master, base;
    logic [16:0] swing;
    logic [3:0]  ch [4];
    channel_result_t r;
    master = in_bus.external_select ? in_bus.ext_clock_inc : in_bus.internal_increment;
    swing  = 17'(in_bus.swing_knob >> 2);
    ch[0]  = 4'(UnityChoice);
    ch[1]  = knob_choice(in_bus.ratio_knob_b);
    ch[2]  = knob_choice(in_bus.ratio_knob_c);
    ch[3]  = knob_choice(in_bus.ratio_knob_d);
    for (int k = 0; k < 4; k++) begin
      base         = ratio_scaled(master, ch[k]);
      r.chan       = 2'(k);
      r.choice     = ch[k];
      r.first_inc  = half_inc(base, 17'(SwingUnity) + swing);
      r.second_inc = half_inc(base, 17'(SwingUnity) - swing);
      r.ext        = in_bus.external_select;
      r.last       = (k == 3);
      pending_q.push_back(r);
    end
  endtask

  assign pending_beats = pending_q.size();

  // Watch both buses at each edge and compare output beats in order.
  always @(posedge clk) begin
    channel_result_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.channel, out_bus.ratio_choice, out_bus.first_half_increment,
               out_bus.second_half_increment, out_bus.external_sync, out_bus.last};
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected chan %0d choice %0d first %h second %h ext %b last %b",
                     $time, want.chan, want.choice, want.first_inc, want.second_inc,
                     want.ext, want.last);
            $display("%0t:          actual chan %0d choice %0d first %h second %h ext %b last %b",
                     $time, got.chan, got.choice, got.first_inc, got.second_inc,
                     got.ext, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) predict_channels();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb import crsi_pkg::*;;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending_beats;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  crsi_in_if  in_bus ();
  crsi_out_if out_bus ();

  clock_ratio_swing_increments DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  crsi_scoreboard checker_inst (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .out_bus      (out_bus),
    .fail_count   (fail_count),
    .pending_beats(pending_beats)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_bus.valid              = 1'b0;
    in_bus.external_select    = 1'b0;
    in_bus.ext_clock_inc      = '0;
    in_bus.internal_increment = '0;
    in_bus.ratio_knob_b       = '0;
    in_bus.ratio_knob_c       = '0;
    in_bus.ratio_knob_d       = '0;
    in_bus.swing_knob         = '0;
    out_bus.ready             = 1'b0;
  end

  // Receiver stalls at the current rate.
  always @(posedge clk) begin
    out_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one control beat and hold it until accepted; gaps are random.
  task automatic send_beat(input logic sel, input logic [31:0] ext_inc,
                           input logic [31:0] int_inc, input logic [15:0] kb,
                           input logic [15:0] kc, input logic [15:0] kd,
                           input logic [15:0] sw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid              <= 1'b1;
    in_bus.external_select    <= sel;
    in_bus.ext_clock_inc      <= ext_inc;
    in_bus.internal_increment <= int_inc;
    in_bus.ratio_knob_b       <= kb;
    in_bus.ratio_knob_c       <= kc;
    in_bus.ratio_knob_d       <= kd;
    in_bus.swing_knob         <= sw;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_master();
    case ($urandom_range(3))
      0:       return $urandom_range(64);
      1:       return 32'hFFFF_FFFF - $urandom_range(64);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_knob();
    case ($urandom_range(3))
      0:       return $urandom_range(15);
      1:       return 16'hFFFF - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 84;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every ratio choice, zero results, wraps.
    send_beat(1'b0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(1'b0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF);
    send_beat(1'b1, 32'd1, 32'hFFFF_FFFF, 16'd0, 16'd5958, 16'd11916, 16'hFFFC);
    send_beat(1'b0, 32'd0, 32'd7, 16'd0, 16'd0, 16'd0, 16'd3);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'd5, 16'd0, 16'd0, 16'd0, 16'h0000);
    send_beat(1'b0, 32'hAAAA_5555, 32'h8000_0000, 16'hFFFF, 16'hE000, 16'hC000, 16'hFFFF);
    for (int c = 0; c < RatioCount; c++)
      send_beat(c[0], $urandom, $urandom, 16'((c * 65536 + 10) / 11),
                16'(((c + 1) * 65536) / 11 - 1), 16'((c * 65536 + 10) / 11), 16'hAAAA);
    send_beat(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555);

    // Random beats in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 84;
        recv_idle_pct = 30;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (80)
        send_beat($urandom_range(1), rand_master(), rand_master(), rand_knob(),
                  rand_knob(), rand_knob(), rand_knob());
    end
    in_bus.valid <= 1'b0;

    while (pending_beats != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
